FILE: sv/hcoc_pkg.sv
// ----------------------------------------------------------------------------
// hcoc_pkg
// Shared types and constants for the chi-square bin comparison block.
// ----------------------------------------------------------------------------
`default_nettype none
package hcoc_pkg;
    localparam int TOP_K   = 8;
    localparam int TOP_W   = 3;
    localparam int FILL_W  = 4;
    localparam int CNT_W   = 17;
    localparam logic [CNT_W-1:0] CNT_CAP = 17'd65536;
    localparam int ACC_W   = 48;
    localparam int SIG_W   = 32;
    localparam int BIN_W   = 16;
    localparam int VAL_W   = 24;

    localparam logic [2:0] REG_NSIGMA   = 3'd0;
    localparam logic [2:0] REG_MAXSIGMA = 3'd1;
    localparam logic [2:0] REG_GREEN    = 3'd2;
    localparam logic [2:0] REG_RED      = 3'd3;
    localparam logic [2:0] REG_NPRINT   = 3'd4;

    localparam logic [1:0] Q_GREEN  = 2'd0;
    localparam logic [1:0] Q_YELLOW = 2'd1;
    localparam logic [1:0] Q_RED    = 2'd2;

    typedef struct packed {
        logic load;       // capture input word, start multiply
        logic div_start;  // start divider
        logic div_step;   // one quotient bit
        logic accum;      // fold term into accumulators
        logic ins_step;   // one top-list shift step
        logic out_sum;    // present summary
        logic out_top;    // present top entry
        logic next_top;   // top entry taken, advance read pointer
        logic clear;      // clear accumulators
    } hcoc_cmd_t;

    typedef struct packed {
        logic skip;       // combined error zero
        logic sat;        // term saturates
        logic div_done;
        logic is_outlier;
        logic ins_done;
        logic last;
        logic top_last;   // current top entry is the last to print
        logic none;       // no top entries to print
    } hcoc_sts_t;
endpackage
`default_nettype wire

FILE: sv/histogram_chisq_outlier_check.sv
// ----------------------------------------------------------------------------
// histogram_chisq_outlier_check
// Pearson chi-square bin comparison with sorted top-outlier report.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                         | tuser
//  s_axis  | in  | bin_id, observed, expected, obs_err, exp_err     | final_bin via tlast
//  m_axis  | out | flagged_bin, sigma_sq, chisq_total, used, count, | kind
//          |     | quality                                           | tlast=end_of_report
//  cfg     | in  | wr_en, wr_index, wr_data (32b)                    | -
//
// One word at a time: accept, multiply, decide, a restoring divide of 32
// quotient bits (one bit per divider step), accumulate and 1 to 8 top-list
// steps for an outlier. A bin with zero combined error skips the divider
// and the accumulators; a saturated term skips the divider.
// A final bin then presents one summary word and up to 8 top words (print
// count capped by kept entries), each held until taken; input blocked meanwhile.
// Synchronous active-low reset clears counters and status; list contents
// are not cleared, only the fill count.
// ----------------------------------------------------------------------------
`default_nettype none
module histogram_chisq_outlier_check import hcoc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // bin_id[15:0] observed[39:16] expected[63:40] observed_error[87:64]
    // expected_error[111:88]
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // flagged_bin[15:0] outlier_sigma_sq[47:16] chisq_total[95:48]
    // used_bins[112:96] outlier_count[129:113] quality[131:130], zero fill
    output logic [135:0]      m_tdata,
    output logic              m_tlast,
    // kind[0]
    output logic              m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_wr_index,
    input  wire logic [31:0]  cfg_wr_data
);
    hcoc_cmd_t cmd;
    hcoc_sts_t sts;

    logic [SIG_W-1:0] nsigma_reg, maxsig_reg;
    logic [CNT_W-1:0] green_reg, red_reg;
    logic [3:0]       nprint_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nsigma_reg <= 32'd65536;
            maxsig_reg <= 32'd65536;
            green_reg  <= '0;
            red_reg    <= '0;
            nprint_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_NSIGMA:   nsigma_reg <= cfg_wr_data;
                REG_MAXSIGMA: maxsig_reg <= cfg_wr_data;
                REG_GREEN:    green_reg  <= cfg_wr_data[CNT_W-1:0];
                REG_RED:      red_reg    <= cfg_wr_data[CNT_W-1:0];
                REG_NPRINT:   nprint_reg <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    logic [BIN_W-1:0] o_bin;
    logic [SIG_W-1:0] o_sig;
    logic [ACC_W-1:0] o_chi;
    logic [CNT_W-1:0] o_used, o_cnt;
    logic [1:0]       o_q;

    hcoc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    hcoc_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .bin_id           (s_tdata[15:0]),
        .observed         (s_tdata[39:16]),
        .expected         (s_tdata[63:40]),
        .observed_error   (s_tdata[87:64]),
        .expected_error   (s_tdata[111:88]),
        .final_bin        (s_tlast),
        .nsigma_sq        (nsigma_reg),
        .max_sigma_sq     (maxsig_reg),
        .green_limit      (green_reg),
        .red_limit        (red_reg),
        .print_limit      (nprint_reg),
        .kind             (m_tuser),
        .flagged_bin      (o_bin),
        .outlier_sigma_sq (o_sig),
        .chisq_total      (o_chi),
        .used_bins        (o_used),
        .outlier_count    (o_cnt),
        .quality          (o_q),
        .end_of_report    (m_tlast)
    );

    assign m_tdata = {4'd0, o_q, o_cnt, o_used, o_chi, o_sig, o_bin};
endmodule
`default_nettype wire

FILE: sv/hcoc_ctrl.sv
// ----------------------------------------------------------------------------
// hcoc_ctrl
// Sequencer for capture, division, insertion and report output.
// ----------------------------------------------------------------------------
`default_nettype none
module hcoc_ctrl import hcoc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output hcoc_cmd_t      cmd,
    input  wire hcoc_sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_TOP  = 3'd6;
    localparam logic [2:0] S_MUL  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // squares registered; diff^2 and combined error being formed
                state_next = S_PREP;
            end
            S_PREP: begin
                // product registered; decide path
                if (sts.skip) begin
                    state_next = sts.last ? S_SUM : S_IDLE;
                end else if (sts.sat) begin
                    state_next = S_ACC;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = S_ACC;
            end
            S_ACC: begin
                cmd.accum = 1'b1;
                if (sts.is_outlier)   state_next = S_INS;
                else if (sts.last)    state_next = S_SUM;
                else                  state_next = S_IDLE;
            end
            S_INS: begin
                cmd.ins_step = 1'b1;
                if (sts.ins_done) state_next = sts.last ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                out_valid   = 1'b1;
                cmd.out_sum = 1'b1;
                if (out_ready) begin
                    if (sts.none) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_TOP;
                    end
                end
            end
            S_TOP: begin
                out_valid   = 1'b1;
                cmd.out_top = 1'b1;
                if (out_ready) begin
                    cmd.next_top = 1'b1;
                    if (sts.top_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/hcoc_dp.sv
// ----------------------------------------------------------------------------
// hcoc_dp
// Datapath: squares, restoring divider, accumulators, sorted top list.
// ----------------------------------------------------------------------------
`default_nettype none
module hcoc_dp import hcoc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hcoc_cmd_t         cmd,
    output hcoc_sts_t              sts,
    input  wire logic [BIN_W-1:0]  bin_id,
    input  wire logic [VAL_W-1:0]  observed,
    input  wire logic [VAL_W-1:0]  expected,
    input  wire logic [VAL_W-1:0]  observed_error,
    input  wire logic [VAL_W-1:0]  expected_error,
    input  wire logic              final_bin,
    input  wire logic [SIG_W-1:0]  nsigma_sq,
    input  wire logic [SIG_W-1:0]  max_sigma_sq,
    input  wire logic [CNT_W-1:0]  green_limit,
    input  wire logic [CNT_W-1:0]  red_limit,
    input  wire logic [3:0]        print_limit,
    output logic                   kind,
    output logic [BIN_W-1:0]       flagged_bin,
    output logic [SIG_W-1:0]       outlier_sigma_sq,
    output logic [ACC_W-1:0]       chisq_total,
    output logic [CNT_W-1:0]       used_bins,
    output logic [CNT_W-1:0]       outlier_count,
    output logic [1:0]             quality,
    output logic                   end_of_report
);
    // captured operands and products
    logic [BIN_W-1:0] bin_reg;
    logic             last_reg;
    logic [VAL_W-1:0] diff_reg;
    logic [47:0]      num_reg;
    logic [48:0]      den_reg;
    logic [47:0]      oesq_reg, eesq_reg;
    logic             prod_reg;  // set after load: squares ready
    // prod_done marks PREP cycle (den/num valid)
    logic             prod_done_reg;
    // divider
    logic [49:0]      rem_reg;
    logic [SIG_W-1:0] q_reg;
    logic [5:0]       dcnt_reg;
    // accumulators
    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] used_reg, over_reg;
    logic             veto_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SIG_W-1:0] top_sig_reg [TOP_K];
    logic [BIN_W-1:0] top_bin_reg [TOP_K];
    // insertion walker: k steps down from last slot
    logic [FILL_W-1:0] ins_k_reg;
    logic [TOP_W-1:0]  rd_reg;
    logic [FILL_W-1:0] nprint;

    logic [50:0] rem_sh;
    logic [48:0] acc_sum;

    assign rem_sh  = {rem_reg, 1'b0};
    assign acc_sum = {1'b0, acc_reg} + {17'd0, q_reg};

    always_comb begin
        nprint = print_limit;
        if (nprint > FILL_W'(TOP_K)) nprint = FILL_W'(TOP_K);
        if (nprint > fill_reg)       nprint = fill_reg;
    end

    // walker: slot ins_k takes new item if previous slot is >= s or k==0
    logic [TOP_W-1:0] ins_slot;
    logic             prev_ge;
    assign ins_slot = ins_k_reg[TOP_W-1:0];
    assign prev_ge  = (ins_k_reg == '0) ? 1'b1
                    : (top_sig_reg[ins_slot - TOP_W'(1)] >= q_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg  <= bin_id;
            last_reg <= final_bin;
            diff_reg <= (observed >= expected) ? observed - expected : expected - observed;
            oesq_reg <= 48'(observed_error) * 48'(observed_error);
            eesq_reg <= 48'(expected_error) * 48'(expected_error);
        end
        if (prod_reg) begin
            num_reg <= 48'(diff_reg) * 48'(diff_reg);
            den_reg <= {1'b0, oesq_reg} + {1'b0, eesq_reg};
        end
        if (cmd.div_start) begin
            rem_reg  <= {2'b0, num_reg};
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {2'b0, den_reg}) begin
                rem_reg <= 50'(rem_sh - {2'b0, den_reg});
                q_reg   <= {q_reg[SIG_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[49:0];
                q_reg   <= {q_reg[SIG_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (sts.sat && !cmd.div_start && prod_done_reg) q_reg <= '1;
        if (cmd.accum) begin
            ins_k_reg <= (fill_reg < FILL_W'(TOP_K)) ? fill_reg : FILL_W'(TOP_K - 1);
        end else if (cmd.ins_step && !prev_ge) begin
            ins_k_reg <= ins_k_reg - FILL_W'(1);
        end
        if (cmd.ins_step) begin
            if (prev_ge) begin
                if (!(fill_reg == FILL_W'(TOP_K) && top_sig_reg[TOP_K-1] >= q_reg)) begin
                    top_sig_reg[ins_slot] <= q_reg;
                    top_bin_reg[ins_slot] <= bin_reg;
                end
            end else begin
                top_sig_reg[ins_slot] <= top_sig_reg[ins_slot - TOP_W'(1)];
                top_bin_reg[ins_slot] <= top_bin_reg[ins_slot - TOP_W'(1)];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg      <= 1'b0;
            prod_done_reg <= 1'b0;
            acc_reg       <= '0;
            used_reg      <= '0;
            over_reg      <= '0;
            veto_reg      <= 1'b0;
            fill_reg      <= '0;
            rd_reg        <= '0;
        end else begin
            prod_reg      <= cmd.load;
            prod_done_reg <= prod_reg;
            if (cmd.clear) begin
                acc_reg  <= '0;
                used_reg <= '0;
                over_reg <= '0;
                veto_reg <= 1'b0;
                fill_reg <= '0;
                rd_reg   <= '0;
            end else begin
                if (cmd.accum) begin
                    acc_reg <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                    if (used_reg < CNT_CAP) used_reg <= used_reg + CNT_W'(1);
                    if (q_reg >= nsigma_sq) begin
                        if (over_reg < CNT_CAP) over_reg <= over_reg + CNT_W'(1);
                        if (q_reg >= max_sigma_sq) veto_reg <= 1'b1;
                    end
                end
                if (cmd.ins_step && prev_ge && fill_reg < FILL_W'(TOP_K))
                    fill_reg <= fill_reg + FILL_W'(1);
                if (cmd.next_top) rd_reg <= rd_reg + TOP_W'(1);
            end
        end
    end

    // PREP occurs while prod_done_reg is high
    assign sts.skip       = (den_reg == '0);
    assign sts.sat        = ({1'b0, num_reg} >= den_reg);
    assign sts.div_done   = (dcnt_reg == 6'd31);
    assign sts.is_outlier = (q_reg >= nsigma_sq);
    assign sts.ins_done   = prev_ge;
    assign sts.last       = last_reg;
    assign sts.top_last   = ({1'b0, rd_reg} + FILL_W'(1) == nprint);
    assign sts.none       = (nprint == '0);

    always_comb begin
        kind             = cmd.out_top;
        flagged_bin      = cmd.out_top ? top_bin_reg[rd_reg] : '0;
        outlier_sigma_sq = cmd.out_top ? top_sig_reg[rd_reg] : '0;
        chisq_total      = cmd.out_sum ? acc_reg  : '0;
        used_bins        = cmd.out_sum ? used_reg : '0;
        outlier_count    = cmd.out_sum ? over_reg : '0;
        if (!cmd.out_sum)                              quality = Q_GREEN;
        else if (over_reg <= green_limit && !veto_reg) quality = Q_GREEN;
        else if (over_reg < red_limit && !veto_reg)    quality = Q_YELLOW;
        else                                           quality = Q_RED;
        end_of_report    = cmd.out_sum ? sts.none : sts.top_last;
    end
endmodule
`default_nettype wire

FILE: verif/histogram_chisq_outlier_check_scoreboard.sv
// ----------------------------------------------------------------------------
// histogram_chisq_outlier_check_scoreboard
// Watches both stream channels and the register port, predicts the report
// words of every histogram and compares them with the words the block sends.
// ----------------------------------------------------------------------------
`default_nettype none
module histogram_chisq_outlier_check_scoreboard import hcoc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [135:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_wr_index,
    input  wire logic [31:0]  cfg_wr_data,
    output int                fail_count,
    output int                pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             kind;
        logic [BIN_W-1:0] bin;
        logic [SIG_W-1:0] sigma;
        logic [ACC_W-1:0] chisq;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] count;
        logic [1:0]       quality;
        logic             eor;
    } report_word_t;

    report_word_t report_q[$];

    logic [SIG_W-1:0] thr_sig, veto_sig;
    logic [CNT_W-1:0] green_lim, red_lim;
    logic [3:0]       n_print;

    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] used_cnt, over_cnt;
    logic             veto;
    logic [SIG_W-1:0] list_sig[TOP_K];
    logic [BIN_W-1:0] list_bin[TOP_K];
    int               list_fill;

    assign pending_words = report_q.size();

    // restoring division, floor(num * 2^32 / den), saturating
    function automatic logic [SIG_W-1:0] sigma_sq(logic [63:0] num, logic [63:0] den);
        logic [63:0] r;
        logic [31:0] q;
        if (num >= den) return '1;
        r = num;
        q = '0;
        for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    task automatic add_to_list(logic [SIG_W-1:0] s, logic [BIN_W-1:0] b);
        int pos;
        int k;
        pos = 0;
        while (pos < list_fill && list_sig[pos] >= s) pos++;
        if (pos >= TOP_K) return;
        k = (list_fill < TOP_K) ? list_fill : TOP_K - 1;
        while (k > pos) begin
            list_sig[k] = list_sig[k-1];
            list_bin[k] = list_bin[k-1];
            k--;
        end
        list_sig[pos] = s;
        list_bin[pos] = b;
        if (list_fill < TOP_K) list_fill++;
    endtask

    task automatic take_bin(logic [111:0] d, logic last);
        logic [63:0] oe, ee, err2, diff, o, e;
        logic [SIG_W-1:0] s;
        logic [ACC_W:0] sum;
        report_word_t w;
        int np;
        o = 64'(d[39:16]);
        e = 64'(d[63:40]);
        oe = 64'(d[87:64]);
        ee = 64'(d[111:88]);
        err2 = oe * oe + ee * ee;
        if (err2 != 0) begin
            diff = (o >= e) ? o - e : e - o;
            s = sigma_sq(diff * diff, err2);
            sum = {1'b0, acc} + {17'd0, s};
            acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            if (used_cnt < CNT_CAP) used_cnt++;
            if (s >= thr_sig) begin
                if (over_cnt < CNT_CAP) over_cnt++;
                if (s >= veto_sig) veto = 1'b1;
                add_to_list(s, d[15:0]);
            end
        end
        if (!last) return;
        np = int'(n_print);
        if (np > TOP_K) np = TOP_K;
        if (np > list_fill) np = list_fill;
        w = '0;
        w.chisq = acc;
        w.used = used_cnt;
        w.count = over_cnt;
        if (over_cnt <= green_lim && !veto) w.quality = Q_GREEN;
        else if (over_cnt < red_lim && !veto) w.quality = Q_YELLOW;
        else w.quality = Q_RED;
        w.eor = (np == 0);
        report_q.insert(report_q.size(), w);
        for (int k = 0; k < np; k++) begin
            w = '0;
            w.kind = 1'b1;
            w.bin = list_bin[k];
            w.sigma = list_sig[k];
            w.eor = (k + 1 == np);
            report_q.insert(report_q.size(), w);
        end
        acc = '0;
        used_cnt = '0;
        over_cnt = '0;
        veto = 1'b0;
        list_fill = 0;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_word();
        report_word_t w;
        if (report_q.size() == 0) begin
            report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
            return;
        end
        w = report_q.pop_front();
        if (m_tuser !== w.kind) report_mismatch("kind", m_tuser, w.kind);
        if (m_tdata[15:0] !== w.bin) report_mismatch("flagged_bin", m_tdata[15:0], w.bin);
        if (m_tdata[47:16] !== w.sigma)
            report_mismatch("outlier_sigma_sq", m_tdata[47:16], w.sigma);
        if (m_tdata[95:48] !== w.chisq) report_mismatch("chisq_total", m_tdata[95:48], w.chisq);
        if (m_tdata[112:96] !== w.used) report_mismatch("used_bins", m_tdata[112:96], w.used);
        if (m_tdata[129:113] !== w.count)
            report_mismatch("outlier_count", m_tdata[129:113], w.count);
        if (m_tdata[131:130] !== w.quality)
            report_mismatch("quality", m_tdata[131:130], w.quality);
        if (m_tlast !== w.eor) report_mismatch("end_of_report", m_tlast, w.eor);
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_sig <= 32'h10000;
            veto_sig <= 32'h10000;
            green_lim <= '0;
            red_lim <= '0;
            n_print <= 4'd1;
            acc = '0;
            used_cnt = '0;
            over_cnt = '0;
            veto = 1'b0;
            list_fill = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_NSIGMA:   thr_sig <= cfg_wr_data;
                    REG_MAXSIGMA: veto_sig <= cfg_wr_data;
                    REG_GREEN:    green_lim <= cfg_wr_data[CNT_W-1:0];
                    REG_RED:      red_lim <= cfg_wr_data[CNT_W-1:0];
                    REG_NPRINT:   n_print <= cfg_wr_data[3:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) check_word();
            if (s_tvalid && s_tready) take_bin(s_tdata, s_tlast);
        end
    end
endmodule
`default_nettype wire

FILE: verif/histogram_chisq_outlier_check_test.sv
// ----------------------------------------------------------------------------
// histogram_chisq_outlier_check_test
// Drives histograms of bins into the block, programs the thresholds between
// histograms, stalls both channels at random, and reports the verdict of the
// scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none
module histogram_chisq_outlier_check_test;
    import hcoc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;   // cycles with no word moving
    localparam int DRAIN_WAIT  = 100;     // settling wait after the last report word

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_index;
    logic [31:0]  cfg_wr_data;
    int           fail_count;
    int           pending_words;
    int           idle_cycles = 0;
    int           gap_left;         // sender gap still to run
    int           stall_mode = 0;   // receiver pattern selector

    histogram_chisq_outlier_check dut (.*);

    histogram_chisq_outlier_check_scoreboard sb (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: sometimes always ready, sometimes random, sometimes long holds.
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Watchdog on cycles without any word accepted.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for all report words, then the block's own settling time.
    task automatic drain();
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // One bin; the sender idles in bursts before raising valid.
    task automatic send_bin(logic [15:0] id, logic [23:0] o, logic [23:0] e,
                            logic [23:0] oe, logic [23:0] ee, logic last);
        if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
        @(posedge aclk);   // valid low between words
        while (gap_left > 0) begin
            gap_left--;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ee, oe, e, o, id};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Random bin, mostly with small errors so outliers show up often.
    task automatic send_random(logic last);
        logic [23:0] o, e, oe, ee;
        o = 24'($urandom());
        e = ($urandom_range(0, 1) != 0) ? 24'(o + $urandom_range(0, 64) - 32)
                                         : 24'($urandom());
        case ($urandom_range(0, 4))
            0: begin oe = 24'($urandom()); ee = 24'($urandom()); end
            1: begin oe = '0; ee = '0; end
            default: begin
                oe = 24'($urandom_range(0, 4096));
                ee = 24'($urandom_range(0, 4096));
            end
        endcase
        send_bin(16'($urandom()), o, e, oe, ee, last);
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        cfg_wr_en = 0;
        cfg_wr_index = REG_NSIGMA;
        cfg_wr_data = '0;
        gap_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed histogram under reset settings: field extremes, skipped bin,
        // saturated term, equal sigmas kept in arrival order.
        send_bin(16'h0000, 24'h0, 24'h0, 24'h0, 24'h0, 0);
        send_bin(16'hFFFF, 24'hFFFFFF, 24'h0, 24'h1, 24'h0, 0);
        send_bin(16'h1234, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
        send_bin(16'h0001, 24'd10, 24'd7, 24'h100, 24'h0, 0);
        send_bin(16'h0002, 24'd7, 24'd10, 24'h0, 24'h100, 0);
        send_bin(16'h0003, 24'd5, 24'd5, 24'h80, 24'h80, 1);
        drain();

        // Full top list with drops, report as long as the list, yellow quality.
        write_reg(REG_NPRINT, 32'd8);
        write_reg(REG_MAXSIGMA, 32'hFFFFFFFF);
        write_reg(REG_GREEN, 32'd3);
        write_reg(REG_RED, 32'd20);
        for (int i = 0; i < 12; i++)
            send_bin(16'(i), 24'(100 + i), 24'd100, 24'h100, 24'h0, i == 11);
        drain();

        // Report with no top entries and oversized writes.
        write_reg(REG_NSIGMA, 32'hFFFFFFFF);
        write_reg(REG_NPRINT, 32'hFFFFFFFF);
        write_reg(REG_RED, 32'hFFFFFFFF);
        write_reg(REG_GREEN, 32'h0);
        send_bin(16'h0042, 24'd3, 24'd1, 24'h100, 24'h100, 1);
        drain();

        // Random histograms under changing settings.
        for (int h = 0; h < 24; h++) begin
            int len;
            len = $urandom_range(1, 14);
            if (h == 6) drain();
            for (int b = 0; b < len; b++) send_random(b == len - 1);
            if (h % 4 == 3) begin
                drain();
                write_reg(REG_NSIGMA, $urandom_range(0, 3) == 0 ? $urandom() :
                          $urandom_range(0, 32'h400000));
                write_reg(REG_MAXSIGMA, $urandom_range(0, 1) ? 32'hFFFFFFFF : $urandom());
                write_reg(REG_GREEN, $urandom_range(0, 6));
                write_reg(REG_RED, $urandom_range(0, 10));
                write_reg(REG_NPRINT, $urandom_range(0, 15));
            end
        end
        // Extreme settings at the end.
        drain();
        write_reg(REG_NSIGMA, 32'd0);
        write_reg(REG_MAXSIGMA, 32'd0);
        write_reg(REG_GREEN, 32'h10000);
        write_reg(REG_RED, 32'h10000);
        write_reg(REG_NPRINT, 32'd8);
        for (int b = 0; b < 10; b++) send_random(b == 9);
        drain();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
